// File: rtl/mi3_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and width functions of the 3x3 matrix inverse
package mi3_pkg;

   localparam int N_ELEM = 9;
   localparam int THR_W = 32;
   localparam int THR_SHIFT = 32;
   localparam logic [THR_W-1:0] THR_RESET = 32'd4295;
   localparam int CSR_AW = 3;
   localparam logic [CSR_AW-3:0] CSR_IDX_DET_THRESHOLD = 1'b0;

   // operand indices of each cofactor: e[0]*e[1] - e[2]*e[3]
   localparam logic [3:0] COF_IDX [N_ELEM][4] = '{
      '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
      '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
      '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
   };

   typedef struct packed {
      logic valid;
      logic singular;
      logic neg;
   } lane_ctl_type;

   function automatic int det_w(input int w);
      return 3 * w + 3;
   endfunction

   function automatic int den_w(input int w);
      return 3 * w + 4;
   endfunction

   function automatic int num_w(input int w, input int f);
      int a;
      int b;
      a = 2 * w + 2 * f + 2;
      b = 3 * w + 3;
      return ((a > b) ? a : b) + 1;
   endfunction

   function automatic int div_w(input int w, input int f);
      int a;
      int b;
      a = num_w(w, f);
      b = den_w(w) + w;
      return (a > b) ? a : b;
   endfunction

   function automatic int latency(input int w);
      return w + 8;
   endfunction

endpackage

// File: rtl/mi3_det.sv
`timescale 1ns / 1ps
// cofactor, determinant, singular test and divider operand pipeline
module mi3_det #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic signed [DATA_WIDTH-1:0] elem [mi3_pkg::N_ELEM],
   input  logic [mi3_pkg::THR_W-1:0] threshold,
   output mi3_pkg::lane_ctl_type ctl [mi3_pkg::N_ELEM],
   output logic [mi3_pkg::num_w(DATA_WIDTH, FRAC_BITS)-1:0] num [mi3_pkg::N_ELEM],
   output logic [mi3_pkg::den_w(DATA_WIDTH)-1:0] den
);
   localparam int N = mi3_pkg::N_ELEM;
   localparam int W = DATA_WIDTH;
   localparam int PW = 2 * W;
   localparam int CW = 2 * W + 1;
   localparam int MW = 2 * W + 1;
   localparam int DW = mi3_pkg::det_w(W);
   localparam int NW = mi3_pkg::num_w(W, FRAC_BITS);
   localparam int DENW = mi3_pkg::den_w(W);
   localparam int SA = DW + mi3_pkg::THR_SHIFT;
   localparam int SB = mi3_pkg::THR_W + 3 * FRAC_BITS;
   localparam int SW = (SA > SB) ? SA : SB;

   logic [6:1] vld_ff;
   logic signed [PW-1:0] pa_ff [N];
   logic signed [PW-1:0] pb_ff [N];
   logic signed [W-1:0] e1_ff [3];
   logic signed [W-1:0] e2_ff [3];
   logic signed [CW-1:0] c2_ff [N];
   logic signed [CW-1:0] c3_ff [N];
   logic signed [CW-1:0] c4_ff [N];
   logic signed [MW-1:0] ml_ff [3];
   logic signed [MW-1:0] mh_ff [3];
   logic signed [DW-1:0] det_ff;
   logic [DW-1:0] adet_ff;
   logic dneg_ff;
   logic [CW-1:0] acof_ff [N];
   logic cneg_ff [N];
   logic sing_ff;
   logic neg_ff [N];
   logic [NW-1:0] num_ff [N];
   logic [DENW-1:0] den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[5:1], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N; i++) begin
         pa_ff[i] <= elem[mi3_pkg::COF_IDX[i][0]] * elem[mi3_pkg::COF_IDX[i][1]];
         pb_ff[i] <= elem[mi3_pkg::COF_IDX[i][2]] * elem[mi3_pkg::COF_IDX[i][3]];
         c2_ff[i] <= CW'(pa_ff[i]) - CW'(pb_ff[i]);
         c3_ff[i] <= c2_ff[i];
         c4_ff[i] <= c3_ff[i];
         acof_ff[i] <= c4_ff[i][CW-1] ? CW'(-c4_ff[i]) : CW'(c4_ff[i]);
         cneg_ff[i] <= c4_ff[i][CW-1];
         neg_ff[i] <= cneg_ff[i] ^ dneg_ff;
         num_ff[i] <= (NW'(acof_ff[i]) << (2 * FRAC_BITS + 1)) + NW'(adet_ff);
      end
      for (int j = 0; j < 3; j++) begin
         e1_ff[j] <= elem[j];
         e2_ff[j] <= e1_ff[j];
         ml_ff[j] <= e2_ff[j] * $signed({1'b0, c2_ff[3 * j][W-1:0]});
         mh_ff[j] <= e2_ff[j] * $signed(c2_ff[3 * j][CW-1:W]);
      end
      det_ff <= (DW'(mh_ff[0]) <<< W) + DW'(ml_ff[0])
              + (DW'(mh_ff[1]) <<< W) + DW'(ml_ff[1])
              + (DW'(mh_ff[2]) <<< W) + DW'(ml_ff[2]);
      adet_ff <= det_ff[DW-1] ? DW'(-det_ff) : DW'(det_ff);
      dneg_ff <= det_ff[DW-1];
      sing_ff <= (SW'(adet_ff) << mi3_pkg::THR_SHIFT) <= (SW'(threshold) << (3 * FRAC_BITS));
      den_ff <= DENW'(adet_ff) << 1;
   end

   always_comb begin
      for (int i = 0; i < N; i++) begin
         ctl[i].valid = vld_ff[6];
         ctl[i].singular = sing_ff;
         ctl[i].neg = neg_ff[i];
         num[i] = num_ff[i];
      end
   end

   assign den = den_ff;

endmodule

// File: rtl/mi3_div_lane.sv
`timescale 1ns / 1ps
// pipelined restoring divider lane, one quotient bit per stage
module mi3_div_lane #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  mi3_pkg::lane_ctl_type in_ctl,
   input  logic [mi3_pkg::num_w(DATA_WIDTH, FRAC_BITS)-1:0] num,
   input  logic [mi3_pkg::den_w(DATA_WIDTH)-1:0] den,
   output mi3_pkg::lane_ctl_type out_ctl,
   output logic [DATA_WIDTH-1:0] quot,
   output logic ovf
);
   localparam int W = DATA_WIDTH;
   localparam int DENW = mi3_pkg::den_w(W);
   localparam int XW = mi3_pkg::div_w(W, FRAC_BITS);

   mi3_pkg::lane_ctl_type ctl_ff [W+1];
   logic [XW-1:0] rem_ff [W];
   logic [DENW-1:0] den_ff [W];
   logic [W-1:0] q_ff [W+1];
   logic ovf_ff [W+1];
   logic [XW-1:0] sub_w [W];
   logic ge_w [W];

   always_comb begin
      for (int s = 0; s < W; s++) begin
         sub_w[s] = XW'(den_ff[s]) << (W - 1 - s);
         ge_w[s] = rem_ff[s] >= sub_w[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= W; s++) begin
            ctl_ff[s] <= '0;
         end
      end else begin
         ctl_ff[0] <= in_ctl;
         for (int s = 0; s < W; s++) begin
            ctl_ff[s+1] <= ctl_ff[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= XW'(num);
      den_ff[0] <= den;
      q_ff[0] <= '0;
      ovf_ff[0] <= XW'(num) >= (XW'(den) << W);
      for (int s = 0; s < W; s++) begin
         if (s < W - 1) begin
            rem_ff[s+1] <= ge_w[s] ? rem_ff[s] - sub_w[s] : rem_ff[s];
            den_ff[s+1] <= den_ff[s];
         end
         q_ff[s+1] <= q_ff[s] | (W'(ge_w[s]) << (W - 1 - s));
         ovf_ff[s+1] <= ovf_ff[s];
      end
   end

   assign out_ctl = ctl_ff[W];
   assign quot = q_ff[W];
   assign ovf = ovf_ff[W];

endmodule

// File: rtl/mi3_merge.sv
`timescale 1ns / 1ps
// saturation, sign and singular zeroing of the lane results, output register
module mi3_merge #(
   parameter int DATA_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   input  mi3_pkg::lane_ctl_type ctl [mi3_pkg::N_ELEM],
   input  logic [DATA_WIDTH-1:0] quot [mi3_pkg::N_ELEM],
   input  logic ovf [mi3_pkg::N_ELEM],
   output logic strobe,
   output logic singular,
   output logic [DATA_WIDTH-1:0] res [mi3_pkg::N_ELEM]
);
   localparam int N = mi3_pkg::N_ELEM;
   localparam int W = DATA_WIDTH;
   localparam logic [W-1:0] POS_LIM = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] NEG_LIM = {1'b1, {(W-1){1'b0}}};

   logic [W-1:0] lim_w [N];
   logic [W-1:0] mag_w [N];
   logic [W-1:0] res_in [N];
   logic [W-1:0] res_ff [N];
   logic sing_ff;
   logic strobe_ff;

   always_comb begin
      for (int i = 0; i < N; i++) begin
         lim_w[i] = ctl[i].neg ? NEG_LIM : POS_LIM;
         mag_w[i] = (ovf[i] || (quot[i] > lim_w[i])) ? lim_w[i] : quot[i];
         if (ctl[0].singular) begin
            res_in[i] = '0;
         end else if (ctl[i].neg) begin
            res_in[i] = W'(~mag_w[i] + 1'b1);
         end else begin
            res_in[i] = mag_w[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= ctl[0].valid;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      sing_ff <= ctl[0].singular;
   end

   assign strobe = strobe_ff;
   assign singular = sing_ff;
   assign res = res_ff;

endmodule

// File: rtl/matrix3x3_inverse.sv
`timescale 1ns / 1ps
// top level of the 3x3 matrix inverse by adjugate and pipelined division
// rsp_strobe follows an accepted start through the determinant pipeline, the divider lanes and the merge register
// throughput: one matrix per cycle; busy stays low, nine divider lanes of DATA_WIDTH stages
// the divider pipeline depth sets the latency; the receiver cannot stall and never has to
// reset: synchronous, clears the valid pipeline and loads det_threshold with 4295
module matrix3x3_inverse #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic signed [DATA_WIDTH-1:0] req_a00,
   input  logic signed [DATA_WIDTH-1:0] req_a01,
   input  logic signed [DATA_WIDTH-1:0] req_a02,
   input  logic signed [DATA_WIDTH-1:0] req_a10,
   input  logic signed [DATA_WIDTH-1:0] req_a11,
   input  logic signed [DATA_WIDTH-1:0] req_a12,
   input  logic signed [DATA_WIDTH-1:0] req_a20,
   input  logic signed [DATA_WIDTH-1:0] req_a21,
   input  logic signed [DATA_WIDTH-1:0] req_a22,
   output logic rsp_strobe,
   output logic signed [DATA_WIDTH-1:0] rsp_r00,
   output logic signed [DATA_WIDTH-1:0] rsp_r01,
   output logic signed [DATA_WIDTH-1:0] rsp_r02,
   output logic signed [DATA_WIDTH-1:0] rsp_r10,
   output logic signed [DATA_WIDTH-1:0] rsp_r11,
   output logic signed [DATA_WIDTH-1:0] rsp_r12,
   output logic signed [DATA_WIDTH-1:0] rsp_r20,
   output logic signed [DATA_WIDTH-1:0] rsp_r21,
   output logic signed [DATA_WIDTH-1:0] rsp_r22,
   output logic rsp_singular,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [mi3_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);
   localparam int N = mi3_pkg::N_ELEM;
   localparam int NW = mi3_pkg::num_w(DATA_WIDTH, FRAC_BITS);
   localparam int DENW = mi3_pkg::den_w(DATA_WIDTH);

   logic [mi3_pkg::THR_W-1:0] thr_ff;
   logic csr_sel;
   logic in_valid;
   logic signed [DATA_WIDTH-1:0] elem [N];
   mi3_pkg::lane_ctl_type front_ctl [N];
   logic [NW-1:0] num [N];
   logic [DENW-1:0] den;
   mi3_pkg::lane_ctl_type lane_ctl [N];
   logic [DATA_WIDTH-1:0] quot [N];
   logic ovf [N];
   logic [DATA_WIDTH-1:0] res [N];

   assign busy = 1'b0;
   assign pready = 1'b1;
   assign in_valid = start & ~busy;
   assign csr_sel = paddr[mi3_pkg::CSR_AW-1:2] == mi3_pkg::CSR_IDX_DET_THRESHOLD;
   assign prdata = csr_sel ? thr_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= mi3_pkg::THR_RESET;
      end else if (psel && penable && pwrite && pready && csr_sel) begin
         thr_ff <= pwdata;
      end
   end

   assign elem[0] = req_a00;
   assign elem[1] = req_a01;
   assign elem[2] = req_a02;
   assign elem[3] = req_a10;
   assign elem[4] = req_a11;
   assign elem[5] = req_a12;
   assign elem[6] = req_a20;
   assign elem[7] = req_a21;
   assign elem[8] = req_a22;

   mi3_det #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_det (
      .clock(clock),
      .reset(reset),
      .in_valid(in_valid),
      .elem(elem),
      .threshold(thr_ff),
      .ctl(front_ctl),
      .num(num),
      .den(den)
   );

   for (genvar i = 0; i < N; i++) begin : g_lane
      mi3_div_lane #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane (
         .clock(clock),
         .reset(reset),
         .in_ctl(front_ctl[i]),
         .num(num[i]),
         .den(den),
         .out_ctl(lane_ctl[i]),
         .quot(quot[i]),
         .ovf(ovf[i])
      );
   end

   mi3_merge #(.DATA_WIDTH(DATA_WIDTH)) u_merge (
      .clock(clock),
      .reset(reset),
      .ctl(lane_ctl),
      .quot(quot),
      .ovf(ovf),
      .strobe(rsp_strobe),
      .singular(rsp_singular),
      .res(res)
   );

   assign rsp_r00 = $signed(res[0]);
   assign rsp_r01 = $signed(res[1]);
   assign rsp_r02 = $signed(res[2]);
   assign rsp_r10 = $signed(res[3]);
   assign rsp_r11 = $signed(res[4]);
   assign rsp_r12 = $signed(res[5]);
   assign rsp_r20 = $signed(res[6]);
   assign rsp_r21 = $signed(res[7]);
   assign rsp_r22 = $signed(res[8]);

endmodule

// File: rtl/mi3_checker.sv
`timescale 1ns / 1ps
// port-level checks of the matrix inverse, bound to the top level
module mi3_checker #(
   parameter int DATA_WIDTH = 32
) (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe,
   input logic rsp_singular,
   input logic signed [DATA_WIDTH-1:0] rsp_r00,
   input logic signed [DATA_WIDTH-1:0] rsp_r01,
   input logic signed [DATA_WIDTH-1:0] rsp_r02,
   input logic signed [DATA_WIDTH-1:0] rsp_r10,
   input logic signed [DATA_WIDTH-1:0] rsp_r11,
   input logic signed [DATA_WIDTH-1:0] rsp_r12,
   input logic signed [DATA_WIDTH-1:0] rsp_r20,
   input logic signed [DATA_WIDTH-1:0] rsp_r21,
   input logic signed [DATA_WIDTH-1:0] rsp_r22,
   input logic psel,
   input logic penable,
   input logic pwrite,
   input logic [mi3_pkg::CSR_AW-1:0] paddr,
   input logic [31:0] pwdata,
   input logic [31:0] prdata,
   input logic pready
);
   localparam int LAT = mi3_pkg::latency(DATA_WIDTH);

   // every accepted transaction is followed by a result strobe
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_strobe)
      else $error("accepted transaction gave no result");

   // no result without an accepted transaction
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LAT))
      else $error("result without a transaction");

   // singular results are all zero
   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_singular) |->
         (rsp_r00 == '0 && rsp_r01 == '0 && rsp_r02 == '0 &&
          rsp_r10 == '0 && rsp_r11 == '0 && rsp_r12 == '0 &&
          rsp_r20 == '0 && rsp_r21 == '0 && rsp_r22 == '0))
      else $error("singular result not zero");

   // threshold reads back what was written
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && pready && paddr[mi3_pkg::CSR_AW-1] == 1'b0) |=>
         (paddr[mi3_pkg::CSR_AW-1] != 1'b0 || prdata == $past(pwdata)))
      else $error("threshold readback mismatch");

endmodule

bind matrix3x3_inverse mi3_checker #(.DATA_WIDTH(DATA_WIDTH)) u_mi3_checker (.*);
